// ----- rtl/core/cdm_pkg.sv -----
// shared types, constants and step functions for the circle penetration block
// no dependencies
package cdm_pkg;

  localparam int SQRT_STEPS = 32;
  localparam int DIV_STEPS  = 31;
  localparam int QUEUE_DEPTH = 2;

  localparam logic OP_CIRCLE = 1'b0;
  localparam logic OP_BOX    = 1'b1;

  localparam logic CFG_MIN_DEPTH_CIRCLE = 1'b0;
  localparam logic CFG_MIN_DEPTH_BOX    = 1'b1;

  localparam logic [15:0] MIN_DEPTH_CIRCLE_RST = 16'd1;
  localparam logic [15:0] MIN_DEPTH_BOX_RST    = 16'd0;

  localparam logic [30:0] DEPTH_MAX = 31'h7fff_ffff;

  // item handed from the front to the back through the queue
  typedef struct packed {
    logic        miss;
    logic [63:0] sum;
    logic [31:0] limit;
    logic [15:0] eps;
    logic [31:0] ax;
    logic [31:0] az;
    logic        neg_x;
    logic        neg_z;
  } q_entry_t;

  // sideband riding along the root pipeline
  typedef struct packed {
    logic        miss;
    logic [31:0] limit;
    logic [15:0] eps;
    logic [31:0] ax;
    logic [31:0] az;
    logic        neg_x;
    logic        neg_z;
  } side_a_t;

  // sideband riding along the divider pipeline
  typedef struct packed {
    logic        hit;
    logic [30:0] dsat;
    logic        neg_x;
    logic        neg_z;
    logic        len_zero;
  } side_b_t;

  typedef struct packed {
    logic [63:0] n;
    logic [63:0] r;
  } sqrt_state_t;

  typedef struct packed {
    logic [31:0] rem;
    logic        qbit;
  } div_state_t;

  // one digit of the integer square root
  function automatic sqrt_state_t sqrt_step(input sqrt_state_t s, input logic [63:0] bitv);
    sqrt_state_t o;
    logic [63:0] t;
    t = s.r + bitv;
    if (s.n >= t) begin
      o.n = s.n - t;
      o.r = (s.r >> 1) + bitv;
    end else begin
      o.n = s.n;
      o.r = s.r >> 1;
    end
    return o;
  endfunction

  // one restoring division step
  function automatic div_state_t div_step(input logic [31:0] rem, input logic nbit,
                                          input logic [31:0] den);
    div_state_t o;
    logic [32:0] rs;
    logic [32:0] diff;
    rs = {rem, nbit};
    diff = rs - {1'b0, den};
    if (rs >= {1'b0, den}) begin
      o.rem  = diff[31:0];
      o.qbit = 1'b1;
    end else begin
      o.rem  = rs[31:0];
      o.qbit = 1'b0;
    end
    return o;
  endfunction

endpackage

// ----- rtl/core/cdm_front.sv -----
// front end: config registers, accept, direction vector, squares and miss test
// depends on cdm_pkg
module cdm_front (
  input  logic               clk,
  input  logic               rst,
  input  logic               accept,
  input  logic               opcode,
  input  logic signed [31:0] self_center_x,
  input  logic signed [31:0] self_center_z,
  input  logic [30:0]        self_radius,
  input  logic signed [31:0] target_center_x,
  input  logic signed [31:0] target_center_z,
  input  logic [30:0]        target_radius,
  input  logic [30:0]        box_half_x,
  input  logic [30:0]        box_half_z,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               push,
  output cdm_pkg::q_entry_t  push_data
);

  logic [15:0] min_depth_circle;
  logic [15:0] min_depth_box;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      min_depth_circle <= cdm_pkg::MIN_DEPTH_CIRCLE_RST;
      min_depth_box    <= cdm_pkg::MIN_DEPTH_BOX_RST;
    end else if (cfg_write) begin
      if (cfg_index == cdm_pkg::CFG_MIN_DEPTH_CIRCLE) min_depth_circle <= cfg_data;
      if (cfg_index == cdm_pkg::CFG_MIN_DEPTH_BOX)    min_depth_box    <= cfg_data;
    end
  end

  logic        v1, v2, v3, v4;
  logic        op1;
  logic [32:0] ex1, ez1;
  logic [30:0] hx1, hz1;
  logic [31:0] lim1, lim2, lim3, lim4;
  logic [15:0] eps1, eps2, eps3, eps4;
  logic [32:0] dx2, dz2;
  logic [31:0] ax3, az3, ax4, az4;
  logic        nx3, nz3, nx4, nz4;
  logic [63:0] sqx4, sqz4, lsq4;

  // stage 1: centre differences, contact limit, threshold by target kind
  always_ff @(posedge clk) begin
    if (rst) v1 <= 1'b0;
    else     v1 <= accept;
    ex1  <= {self_center_x[31], self_center_x} - {target_center_x[31], target_center_x};
    ez1  <= {self_center_z[31], self_center_z} - {target_center_z[31], target_center_z};
    hx1  <= box_half_x;
    hz1  <= box_half_z;
    op1  <= opcode;
    lim1 <= (opcode == cdm_pkg::OP_BOX) ? {1'b0, self_radius}
                                        : {1'b0, self_radius} + {1'b0, target_radius};
    eps1 <= (opcode == cdm_pkg::OP_BOX) ? min_depth_box : min_depth_circle;
  end

  // stage 2: clamp against the box
  logic [33:0] lox, hix, loz, hiz;
  logic [32:0] bdx, bdz;
  always_comb begin
    lox = {ex1[32], ex1} + {3'b000, hx1};
    hix = {ex1[32], ex1} - {3'b000, hx1};
    loz = {ez1[32], ez1} + {3'b000, hz1};
    hiz = {ez1[32], ez1} - {3'b000, hz1};
    if (lox[33])                        bdx = lox[32:0];
    else if (!hix[33] && hix != 34'd0)  bdx = hix[32:0];
    else                                bdx = 33'd0;
    if (loz[33])                        bdz = loz[32:0];
    else if (!hiz[33] && hiz != 34'd0)  bdz = hiz[32:0];
    else                                bdz = 33'd0;
  end

  always_ff @(posedge clk) begin
    if (rst) v2 <= 1'b0;
    else     v2 <= v1;
    dx2  <= (op1 == cdm_pkg::OP_BOX) ? bdx : ex1;
    dz2  <= (op1 == cdm_pkg::OP_BOX) ? bdz : ez1;
    lim2 <= lim1;
    eps2 <= eps1;
  end

  // stage 3: magnitudes and signs
  logic [32:0] ndx, ndz;
  assign ndx = ~dx2 + 33'd1;
  assign ndz = ~dz2 + 33'd1;

  always_ff @(posedge clk) begin
    if (rst) v3 <= 1'b0;
    else     v3 <= v2;
    ax3  <= dx2[32] ? ndx[31:0] : dx2[31:0];
    az3  <= dz2[32] ? ndz[31:0] : dz2[31:0];
    nx3  <= dx2[32];
    nz3  <= dz2[32];
    lim3 <= lim2;
    eps3 <= eps2;
  end

  // stage 4: squares
  always_ff @(posedge clk) begin
    if (rst) v4 <= 1'b0;
    else     v4 <= v3;
    sqx4 <= ax3 * ax3;
    sqz4 <= az3 * az3;
    lsq4 <= lim3 * lim3;
    ax4  <= ax3;
    az4  <= az3;
    nx4  <= nx3;
    nz4  <= nz3;
    lim4 <= lim3;
    eps4 <= eps3;
  end

  // stage 5: squared distance against squared limit
  logic [64:0] sum5;
  assign sum5 = {1'b0, sqx4} + {1'b0, sqz4};

  always_ff @(posedge clk) begin
    if (rst) push <= 1'b0;
    else     push <= v4;
    push_data.miss  <= (sum5 > {1'b0, lsq4});
    push_data.sum   <= sum5[63:0];
    push_data.limit <= lim4;
    push_data.eps   <= eps4;
    push_data.ax    <= ax4;
    push_data.az    <= az4;
    push_data.neg_x <= nx4;
    push_data.neg_z <= nz4;
  end

endmodule

// ----- rtl/core/cdm_queue.sv -----
// two-entry queue between the front end and the back end
// depends on cdm_pkg
module cdm_queue (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  input  cdm_pkg::q_entry_t push_data,
  input  logic              pop_ready,
  output logic              pop_valid,
  output cdm_pkg::q_entry_t pop_data,
  output logic              full
);

  cdm_pkg::q_entry_t mem [cdm_pkg::QUEUE_DEPTH];
  logic       wr_ptr, rd_ptr;
  logic [1:0] count;
  logic       do_push, do_pop;

  assign pop_valid = (count != 2'd0);
  assign full      = (count == 2'd2);
  assign do_push   = push & ~full;
  assign do_pop    = pop_valid & pop_ready;
  assign pop_data  = mem[rd_ptr];

  // entry storage
  always_ff @(posedge clk) begin
    if (do_push) mem[wr_ptr] <= push_data;
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (do_push) wr_ptr <= ~wr_ptr;
      if (do_pop)  rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ----- rtl/core/cdm_sqrt.sv -----
// pipelined integer square root, one result digit per stage
// depends on cdm_pkg
module cdm_sqrt (
  input  logic        clk,
  input  logic [63:0] n_in,
  output logic [31:0] root
);

  cdm_pkg::sqrt_state_t st [cdm_pkg::SQRT_STEPS];

  for (genvar k = 0; k < cdm_pkg::SQRT_STEPS; k++) begin : g_stage
    localparam logic [63:0] BITV = 64'd1 << (2 * (cdm_pkg::SQRT_STEPS - 1 - k));
    if (k == 0) begin : g_first
      always_ff @(posedge clk) begin
        st[k] <= cdm_pkg::sqrt_step({n_in, 64'd0}, BITV);
      end
    end else begin : g_rest
      always_ff @(posedge clk) begin
        st[k] <= cdm_pkg::sqrt_step(st[k-1], BITV);
      end
    end
  end

  assign root = st[cdm_pkg::SQRT_STEPS-1].r[31:0];

endmodule

// ----- rtl/core/cdm_div.sv -----
// pipelined restoring divider, one quotient bit per stage
// depends on cdm_pkg
module cdm_div (
  input  logic        clk,
  input  logic [63:0] num,
  input  logic [31:0] den,
  output logic [cdm_pkg::DIV_STEPS-1:0] quo
);

  localparam int W = cdm_pkg::DIV_STEPS;

  logic [31:0]  rem_q [W];
  logic [31:0]  den_q [W];
  logic [W-1:0] low_q [W];
  logic [W-1:0] quo_q [W];

  for (genvar k = 0; k < W; k++) begin : g_stage
    localparam int B = W - 1 - k;
    cdm_pkg::div_state_t s;
    if (k == 0) begin : g_first
      assign s = cdm_pkg::div_step(num[W+31:W], num[B], den);
      always_ff @(posedge clk) begin
        rem_q[k] <= s.rem;
        den_q[k] <= den;
        low_q[k] <= num[W-1:0];
        quo_q[k] <= {{(W-1){1'b0}}, s.qbit};
      end
    end else begin : g_rest
      assign s = cdm_pkg::div_step(rem_q[k-1], low_q[k-1][B], den_q[k-1]);
      always_ff @(posedge clk) begin
        rem_q[k] <= s.rem;
        den_q[k] <= den_q[k-1];
        low_q[k] <= low_q[k-1];
        quo_q[k] <= {quo_q[k-1][W-2:0], s.qbit};
      end
    end
  end

  assign quo = quo_q[W-1];

endmodule

// ----- rtl/core/cdm_back.sv -----
// back end: length, depth, threshold, push vector and result register
// depends on cdm_pkg, cdm_sqrt, cdm_div
module cdm_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  input  cdm_pkg::q_entry_t  in_data,
  output logic               in_ready,
  output logic               done,
  output logic               hit,
  output logic [30:0]        depth,
  output logic signed [31:0] push_x,
  output logic signed [31:0] push_z
);

  localparam int NA = cdm_pkg::SQRT_STEPS;
  localparam int NB = cdm_pkg::DIV_STEPS;

  // the back end never stalls
  assign in_ready = 1'b1;

  // square root with its sideband
  logic [31:0] len;
  cdm_sqrt u_sqrt (.clk(clk), .n_in(in_data.sum), .root(len));

  cdm_pkg::side_a_t sa [NA];
  logic [NA-1:0]    va;

  always_ff @(posedge clk) begin
    if (rst) va <= '0;
    else     va <= {va[NA-2:0], in_valid};
    sa[0] <= '{miss: in_data.miss, limit: in_data.limit, eps: in_data.eps,
               ax: in_data.ax, az: in_data.az,
               neg_x: in_data.neg_x, neg_z: in_data.neg_z};
    for (int k = 1; k < NA; k++) sa[k] <= sa[k-1];
  end

  // depth, threshold and saturation
  cdm_pkg::side_a_t top_a;
  logic [31:0] dfull;
  assign top_a = sa[NA-1];
  assign dfull = top_a.limit - len;

  logic        v1, v2, v3;
  logic        hit1, hit2, hit3;
  logic [30:0] ds1, ds2, ds3;
  logic [31:0] ax1, az1, len1, len2, len3;
  logic        nx1, nz1, nx2, nz2, nx3, nz3;
  logic [62:0] prx2, prz2;
  logic [63:0] numx3, numz3;

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
    end else begin
      v1 <= va[NA-1];
      v2 <= v1;
      v3 <= v2;
    end
    hit1 <= ~top_a.miss && (dfull >= {16'd0, top_a.eps});
    ds1  <= dfull[31] ? cdm_pkg::DEPTH_MAX : dfull[30:0];
    ax1  <= top_a.ax;
    az1  <= top_a.az;
    nx1  <= top_a.neg_x;
    nz1  <= top_a.neg_z;
    len1 <= len;
    // depth times magnitude
    prx2 <= ds1 * ax1;
    prz2 <= ds1 * az1;
    hit2 <= hit1;
    ds2  <= ds1;
    nx2  <= nx1;
    nz2  <= nz1;
    len2 <= len1;
    // add half the length for rounding
    numx3 <= {1'b0, prx2} + {33'd0, len2[31:1]};
    numz3 <= {1'b0, prz2} + {33'd0, len2[31:1]};
    hit3  <= hit2;
    ds3   <= ds2;
    nx3   <= nx2;
    nz3   <= nz2;
    len3  <= len2;
  end

  // dividers with their sideband
  logic [NB-1:0] qx, qz;
  cdm_div u_div_x (.clk(clk), .num(numx3), .den(len3), .quo(qx));
  cdm_div u_div_z (.clk(clk), .num(numz3), .den(len3), .quo(qz));

  cdm_pkg::side_b_t sb [NB];
  logic [NB-1:0]    vb;

  always_ff @(posedge clk) begin
    if (rst) vb <= '0;
    else     vb <= {vb[NB-2:0], v3};
    sb[0] <= '{hit: hit3, dsat: ds3, neg_x: nx3, neg_z: nz3, len_zero: (len3 == 32'd0)};
    for (int k = 1; k < NB; k++) sb[k] <= sb[k-1];
  end

  // clamp, sign and mask
  cdm_pkg::side_b_t top_b;
  logic [30:0] cqx, cqz;
  logic [31:0] pqx, pqz;
  assign top_b = sb[NB-1];
  assign cqx = (qx > top_b.dsat) ? top_b.dsat : qx;
  assign cqz = (qz > top_b.dsat) ? top_b.dsat : qz;
  assign pqx = top_b.neg_x ? (~{1'b0, cqx} + 32'd1) : {1'b0, cqx};
  assign pqz = top_b.neg_z ? (~{1'b0, cqz} + 32'd1) : {1'b0, cqz};

  // result register
  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= vb[NB-1];
    hit    <= top_b.hit;
    depth  <= top_b.hit ? top_b.dsat : 31'd0;
    push_x <= (top_b.hit && !top_b.len_zero) ? pqx : 32'sd0;
    push_z <= (top_b.hit && !top_b.len_zero) ? pqz : 32'sd0;
  end

endmodule

// ----- rtl/core/circle_collision_depth_mtv.sv -----
// top level of the circle penetration block
// depends on cdm_pkg, cdm_front, cdm_queue, cdm_back
//
//   channel   handshake                 payload
//   config    cfg_write                 cfg_index, cfg_data
//   item in   start high, busy low      opcode, centres, radii, box half extents
//   result    done, one cycle strobe    hit, depth, push_x, push_z
//
// one item per cycle while busy is low; a result passes the front end, the queue,
// the 32 root stages and the 31 divider stages of the back end
// rst clears the thresholds to their defaults and empties every stage
// the result side takes each result as it comes, so busy stays low
module circle_collision_depth_mtv (
  input  logic               clk,
  input  logic               rst,
  input  logic               start,
  output logic               busy,
  input  logic               opcode,
  input  logic signed [31:0] self_center_x,
  input  logic signed [31:0] self_center_z,
  input  logic [30:0]        self_radius,
  input  logic signed [31:0] target_center_x,
  input  logic signed [31:0] target_center_z,
  input  logic [30:0]        target_radius,
  input  logic [30:0]        box_half_x,
  input  logic [30:0]        box_half_z,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data,
  output logic               done,
  output logic               hit,
  output logic [30:0]        depth,
  output logic signed [31:0] push_x,
  output logic signed [31:0] push_z
);

  logic              accept;
  logic              push;
  cdm_pkg::q_entry_t push_data;
  logic              pop_valid, pop_ready;
  cdm_pkg::q_entry_t pop_data;

  assign accept = start & ~busy;

  cdm_front u_front (
    .clk, .rst, .accept, .opcode,
    .self_center_x, .self_center_z, .self_radius,
    .target_center_x, .target_center_z, .target_radius,
    .box_half_x, .box_half_z,
    .cfg_write, .cfg_index, .cfg_data,
    .push, .push_data
  );

  cdm_queue u_queue (
    .clk, .rst, .push, .push_data,
    .pop_ready, .pop_valid, .pop_data,
    .full(busy)
  );

  cdm_back u_back (
    .clk, .rst,
    .in_valid(pop_valid), .in_data(pop_data), .in_ready(pop_ready),
    .done, .hit, .depth, .push_x, .push_z
  );

endmodule

// ----- test/tb_circle_collision_depth_mtv.sv -----
// testbench for circle_collision_depth_mtv: circle-circle and circle-box contacts
// checked against an in-bench predictor; depends on cdm_pkg and the block itself
`timescale 1ns / 100ps

module tb_circle_collision_depth_mtv;

  localparam int LATENCY     = 72;
  localparam int CYCLE_LIMIT = 400000;

  typedef struct {
    logic               op;
    logic signed [31:0] sx;
    logic signed [31:0] sz;
    logic [30:0]        sr;
    logic signed [31:0] tx;
    logic signed [31:0] tz;
    logic [30:0]        tr;
    logic [30:0]        hx;
    logic [30:0]        hz;
  } pair_t;

  typedef struct {
    logic               hit;
    logic [30:0]        depth;
    logic signed [31:0] px;
    logic signed [31:0] pz;
  } contact_t;

  logic               clk;
  logic               rst;
  logic               start;
  logic               busy;
  logic               opcode;
  logic signed [31:0] self_center_x;
  logic signed [31:0] self_center_z;
  logic [30:0]        self_radius;
  logic signed [31:0] target_center_x;
  logic signed [31:0] target_center_z;
  logic [30:0]        target_radius;
  logic [30:0]        box_half_x;
  logic [30:0]        box_half_z;
  logic               cfg_write;
  logic               cfg_index;
  logic [15:0]        cfg_data;
  logic               done;
  logic               hit;
  logic [30:0]        depth;
  logic signed [31:0] push_x;
  logic signed [31:0] push_z;

  contact_t    expected_contacts[$];
  logic [15:0] eps_circle;
  logic [15:0] eps_box;
  int          idle_pct;
  int          error_count;
  int          items_sent;
  int          hits_seen;
  int          results_seen;
  int          cycle_count;

  circle_collision_depth_mtv dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .opcode(opcode),
    .self_center_x(self_center_x), .self_center_z(self_center_z),
    .self_radius(self_radius), .target_center_x(target_center_x),
    .target_center_z(target_center_z), .target_radius(target_radius),
    .box_half_x(box_half_x), .box_half_z(box_half_z),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .done(done), .hit(hit), .depth(depth), .push_x(push_x), .push_z(push_z)
  );

  // 12 ns clock
  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // floor square root, one result bit at a time from the top
  function automatic longint unsigned floor_root(longint unsigned n);
    longint unsigned r;
    longint unsigned t;
    r = 0;
    for (int b = 31; b >= 0; b--) begin
      t = r | (64'd1 << b);
      if (t * t <= n) r = t;
    end
    return r;
  endfunction

  // one push component: depth * |d| / len rounded half away, signed like d
  function automatic logic [31:0] push_axis(longint unsigned dep, longint d,
                                            longint unsigned len);
    longint unsigned mag;
    longint unsigned q;
    mag = (d < 0) ? longint'(-d) : longint'(d);
    q = (dep * mag + len / 2) / len;
    if (q > dep) q = dep;
    return (d < 0) ? 32'(-longint'(q)) : 32'(q);
  endfunction

  // penetration of a circle of reach lim around the reference point
  function automatic contact_t penetration(longint dx, longint dz, longint unsigned lim,
                                           longint unsigned eps);
    contact_t        c;
    longint unsigned ax;
    longint unsigned az;
    logic [64:0]     dist_sq;
    logic [64:0]     reach_sq;
    longint unsigned len;
    longint unsigned dep;
    c = '{hit: 1'b0, depth: '0, px: '0, pz: '0};
    ax = (dx < 0) ? longint'(-dx) : longint'(dx);
    az = (dz < 0) ? longint'(-dz) : longint'(dz);
    dist_sq = {1'b0, ax * ax} + {1'b0, az * az};
    reach_sq = {1'b0, lim * lim};
    if (dist_sq > reach_sq) return c;
    len = floor_root(dist_sq[63:0]);
    dep = lim - len;
    if (dep < eps) return c;
    if (dep > 64'(cdm_pkg::DEPTH_MAX)) dep = 64'(cdm_pkg::DEPTH_MAX);
    c.hit = 1'b1;
    c.depth = dep[30:0];
    if (len != 0) begin
      c.px = push_axis(dep, dx, len);
      c.pz = push_axis(dep, dz, len);
    end
    return c;
  endfunction

  function automatic longint clamp_range(longint v, longint lo, longint hi);
    if (v < lo) return lo;
    if (v > hi) return hi;
    return v;
  endfunction

  // expected contact for one pair under the current thresholds
  function automatic contact_t predict_contact(pair_t p);
    longint cx;
    longint cz;
    if (p.op == cdm_pkg::OP_CIRCLE)
      return penetration(longint'(p.sx) - longint'(p.tx), longint'(p.sz) - longint'(p.tz),
                         longint'(p.sr) + longint'(p.tr), 64'(eps_circle));
    cx = clamp_range(longint'(p.sx), longint'(p.tx) - longint'(p.hx),
                     longint'(p.tx) + longint'(p.hx));
    cz = clamp_range(longint'(p.sz), longint'(p.tz) - longint'(p.hz),
                     longint'(p.tz) + longint'(p.hz));
    return penetration(longint'(p.sx) - cx, longint'(p.sz) - cz, 64'(p.sr), 64'(eps_box));
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    error_count++;
    $display("MISMATCH result %0d %s: got %0d expected %0d", results_seen, what, got, want);
  endtask

  // result checker
  always @(posedge clk) begin
    contact_t want;
    if (!rst && done) begin
      if (expected_contacts.size() == 0) begin
        report_mismatch("results outstanding", 1, 0);
      end else begin
        want = expected_contacts.pop_front();
        if (hit !== want.hit) report_mismatch("hit", longint'(hit), longint'(want.hit));
        if (depth !== want.depth)
          report_mismatch("depth", longint'(depth), longint'(want.depth));
        if (push_x !== want.px) report_mismatch("push_x", longint'(push_x), longint'(want.px));
        if (push_z !== want.pz) report_mismatch("push_z", longint'(push_z), longint'(want.pz));
        if (want.hit) hits_seen++;
      end
      results_seen++;
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d outstanding", cycle_count,
               expected_contacts.size());
      $display("tb_circle_collision_depth_mtv: done, errors");
      $finish;
    end
  end

  // send one item; start stays high across back-to-back items
  task automatic send_item(pair_t p);
    logic b;
    if (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      repeat ($urandom_range(4, 1)) @(posedge clk);
    end
    start <= 1'b1;
    opcode <= p.op;
    self_center_x <= p.sx;
    self_center_z <= p.sz;
    self_radius <= p.sr;
    target_center_x <= p.tx;
    target_center_z <= p.tz;
    target_radius <= p.tr;
    box_half_x <= p.hx;
    box_half_z <= p.hz;
    do begin
      @(negedge clk);
      b = busy;
      @(posedge clk);
    end while (b);
    expected_contacts.push_back(predict_contact(p));
    items_sent++;
  endtask

  task automatic drain;
    start <= 1'b0;
    while (expected_contacts.size() != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  // one register write, with cfg_write low again before the task returns, so writes never collide
  task automatic write_threshold(logic idx, logic [15:0] value);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    cfg_write <= 1'b0;
    @(posedge clk);
    if (idx == cdm_pkg::CFG_MIN_DEPTH_CIRCLE) eps_circle = value;
    else eps_box = value;
  endtask

  function automatic pair_t make_pair(logic op, int sx, int sz, int sr, int tx, int tz,
                                      int tr, int hx, int hz);
    pair_t p;
    p.op = op;
    p.sx = sx; p.sz = sz; p.sr = 31'(sr);
    p.tx = tx; p.tz = tz; p.tr = 31'(tr);
    p.hx = 31'(hx); p.hz = 31'(hz);
    return p;
  endfunction

  // circle targets: overlap, miss, touch, shared centre, saturation, coordinate extremes
  task automatic test_circle_directed;
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 32'h0001_0000, 0, 32'h0001_0000, 0, 0,
                        32'h0001_0000, 0, 0));
    send_item(make_pair(cdm_pkg::OP_CIRCLE, -32'h0003_0000, 32'h0002_0000, 32'h0002_0000,
                        0, 0, 32'h0002_0000, 0, 0));
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 32'h0005_0000, 0, 32'h0001_0000, 0, 0,
                        32'h0001_0000, 0, 0));
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 32'h0002_0000, 0, 32'h0001_0000, 0, 0,
                        32'h0001_0000, 0, 0));
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 1234, -99, 500, 1234, -99, 700, 0, 0));
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 0, 0, 32'h7fff_ffff, 0, 0, 32'h7fff_ffff,
                        0, 0));
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 32'h4000_0000, -32'h4000_0000, 32'h7fff_ffff,
                        0, 0, 32'h7fff_ffff, 0, 0));
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff, 0, 0));
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 32'h8000_0000, 0, 32'h7fff_ffff, 32'h7fff_ffff,
                        0, 32'h7fff_ffff, 0, 0));
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 0, 0, 0, 0, 0, 0, 0, 0));
  endtask

  // box targets: inside, side, corner, far, touching, widest box
  task automatic test_box_directed;
    send_item(make_pair(cdm_pkg::OP_BOX, 10, 20, 32'h0001_0000, 0, 0, 0, 32'h0004_0000,
                        32'h0004_0000));
    send_item(make_pair(cdm_pkg::OP_BOX, 32'h0004_8000, 0, 32'h0001_0000, 0, 0, 0,
                        32'h0004_0000, 32'h0004_0000));
    send_item(make_pair(cdm_pkg::OP_BOX, -32'h0004_8000, -32'h0004_8000, 32'h0001_0000,
                        0, 0, 0, 32'h0004_0000, 32'h0004_0000));
    send_item(make_pair(cdm_pkg::OP_BOX, 32'h0009_0000, 0, 32'h0001_0000, 0, 0, 0,
                        32'h0004_0000, 32'h0004_0000));
    send_item(make_pair(cdm_pkg::OP_BOX, 0, 32'h0005_0000, 32'h0001_0000, 0, 0, 0,
                        32'h0004_0000, 32'h0004_0000));
    send_item(make_pair(cdm_pkg::OP_BOX, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                        32'h8000_0000, 32'h7fff_ffff, 0, 32'h7fff_ffff, 32'h7fff_ffff));
    send_item(make_pair(cdm_pkg::OP_BOX, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff,
                        32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff, 0, 0));
    send_item(make_pair(cdm_pkg::OP_BOX, 5, 5, 0, 5, 5, 0, 0, 0));
  endtask

  // thresholds at both extremes, then touching and shallow contacts again
  task automatic test_thresholds;
    drain();
    write_threshold(cdm_pkg::CFG_MIN_DEPTH_CIRCLE, 16'd0);
    write_threshold(cdm_pkg::CFG_MIN_DEPTH_BOX, 16'hffff);
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 32'h0002_0000, 0, 32'h0001_0000, 0, 0,
                        32'h0001_0000, 0, 0));
    send_item(make_pair(cdm_pkg::OP_BOX, 32'h0005_0000, 0, 32'h0001_0000, 0, 0, 0,
                        32'h0004_0000, 0));
    send_item(make_pair(cdm_pkg::OP_BOX, 32'h0004_8000, 0, 32'h0001_0000, 0, 0, 0,
                        32'h0004_0000, 0));
    send_item(make_pair(cdm_pkg::OP_BOX, 32'h0004_0000, 0, 32'h0002_0000, 0, 0, 0,
                        32'h0004_0000, 0));
    drain();
    write_threshold(cdm_pkg::CFG_MIN_DEPTH_CIRCLE, 16'hffff);
    write_threshold(cdm_pkg::CFG_MIN_DEPTH_BOX, 16'd0);
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 32'h0001_8000, 0, 32'h0001_0000, 0, 0,
                        32'h0001_0000, 0, 0));
    send_item(make_pair(cdm_pkg::OP_CIRCLE, 32'h0000_8000, 0, 32'h0001_0000, 0, 0,
                        32'h0001_0000, 0, 0));
    send_item(make_pair(cdm_pkg::OP_BOX, 32'h0005_0000, 0, 32'h0001_0000, 0, 0, 0,
                        32'h0004_0000, 0));
  endtask

  function automatic logic [30:0] rand_len(bit wide);
    if (wide) return 31'($urandom);
    return 31'($urandom_range(32'h0010_0000));
  endfunction

  // random pairs: mostly close together, some fully random, some huge radii
  task automatic test_random(int count);
    pair_t p;
    int    kind;
    for (int i = 0; i < count; i++) begin
      kind = $urandom_range(9);
      p.op = 1'($urandom_range(1));
      p.tx = $urandom;
      p.tz = $urandom;
      if (kind < 7) begin
        p.sx = p.tx + $signed(32'($urandom_range(32'h0040_0000))) - 32'sh0020_0000;
        p.sz = p.tz + $signed(32'($urandom_range(32'h0040_0000))) - 32'sh0020_0000;
        if (kind == 0) p.sz = p.tz;
        if (kind == 1) begin
          p.sx = p.tx;
          p.sz = p.tz;
        end
      end else begin
        p.sx = $urandom;
        p.sz = $urandom;
      end
      p.sr = rand_len(kind >= 8);
      p.tr = rand_len(kind >= 8);
      p.hx = rand_len(kind == 9);
      p.hz = rand_len(kind == 9);
      send_item(p);
    end
  endtask

  // random thresholds between random phases
  task automatic test_random_thresholds;
    drain();
    write_threshold(cdm_pkg::CFG_MIN_DEPTH_CIRCLE, 16'($urandom));
    write_threshold(cdm_pkg::CFG_MIN_DEPTH_BOX, 16'($urandom));
  endtask

  initial begin
    rst = 1'b1;
    start = 1'b0;
    opcode = cdm_pkg::OP_CIRCLE;
    self_center_x = '0;
    self_center_z = '0;
    self_radius = '0;
    target_center_x = '0;
    target_center_z = '0;
    target_radius = '0;
    box_half_x = '0;
    box_half_z = '0;
    cfg_write = 1'b0;
    cfg_index = cdm_pkg::CFG_MIN_DEPTH_CIRCLE;
    cfg_data = '0;
    eps_circle = cdm_pkg::MIN_DEPTH_CIRCLE_RST;
    eps_box = cdm_pkg::MIN_DEPTH_BOX_RST;
    idle_pct = 0;
    error_count = 0;
    items_sent = 0;
    hits_seen = 0;
    results_seen = 0;
    cycle_count = 0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // reset thresholds first, back to back
    test_circle_directed();
    test_box_directed();
    test_thresholds();

    idle_pct = 14;
    test_random_thresholds();
    test_random(170);
    idle_pct = 45;
    test_random_thresholds();
    test_random(160);
    idle_pct = 0;
    drain();
    write_threshold(cdm_pkg::CFG_MIN_DEPTH_CIRCLE, 16'd0);
    write_threshold(cdm_pkg::CFG_MIN_DEPTH_BOX, 16'd0);
    test_random(170);
    drain();

    $display("covered %0d items, %0d results, %0d hits, thresholds at zero, max and random",
             items_sent, results_seen, hits_seen);
    if (error_count == 0) begin
      $display("tb_circle_collision_depth_mtv: done, clean");
    end else begin
      $display("%0d mismatches", error_count);
      $display("tb_circle_collision_depth_mtv: done, errors");
    end
    $finish;
  end

endmodule
